### rtl/core/suc_pkg.sv
// Shared types and codes for the sorted unique set.
package suc_pkg;

  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 3;

  // Operation codes on the command channel.
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DUMP   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ENTRY    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd6;

  // Command broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  key;
  } cell_ctrl_t;

endpackage

### rtl/core/suc_cmd_if.sv
// Command channel: operation code and operand value.
interface suc_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [suc_pkg::FUNC_W-1:0]          func;
  logic signed [suc_pkg::DATA_W-1:0]   value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

### rtl/core/suc_rsp_if.sv
// Response channel: status, dumped value and last marker.
interface suc_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [suc_pkg::STATUS_W-1:0]        status;
  logic signed [suc_pkg::DATA_W-1:0]   entry_value;
  logic                                last;

  modport source (output valid, output status, output entry_value, output last, input ready);
  modport sink   (input valid, input status, input entry_value, input last, output ready);
endinterface

### rtl/core/suc_cell.sv
// One slot of the sorted chain: holds a value, compares, shifts and rotates.
module suc_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  suc_pkg::cell_ctrl_t               ctrl,
  input  logic signed [suc_pkg::DATA_W-1:0] head_value,
  input  logic signed [suc_pkg::DATA_W-1:0] left_value,
  input  logic                              left_valid,
  input  logic                              left_below,
  input  logic signed [suc_pkg::DATA_W-1:0] right_value,
  input  logic                              right_valid,
  output logic signed [suc_pkg::DATA_W-1:0] value,
  output logic                              valid,
  output logic                              below,
  output logic                              match
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctrl.op)
        suc_pkg::CELL_INS: begin
          // Cells past the slot take the left neighbor; the slot takes the key.
          if (!below) begin
            if (left_below) begin
              valid <= 1'b1;
            end else begin
              valid <= left_valid;
            end
          end
        end
        suc_pkg::CELL_DEL: begin
          if (!below) begin
            valid <= right_valid;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      suc_pkg::CELL_CMP: begin
        below <= valid && (value < ctrl.key);
        match <= valid && (value == ctrl.key);
      end
      suc_pkg::CELL_INS: begin
        if (!below) begin
          value <= left_below ? ctrl.key : left_value;
        end
      end
      suc_pkg::CELL_DEL: begin
        if (!below) begin
          value <= right_value;
        end
      end
      suc_pkg::CELL_ROT: begin
        // The head wraps around to the tail of the occupied run.
        if (valid) begin
          value <= right_valid ? right_value : head_value;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/sorted_unique_set.sv
// Top level of the sorted unique set: control FSM, cell chain and response register.
//
//   channel | role | payload
//   --------+------+----------------------------------
//   cmd     | in   | func, value
//   rsp     | out  | status, entry_value, last
//
// Insert and remove: compare on the cycle after the transfer, then shift in S_APPLY once rsp is free.
// The result is registered from S_APPLY; the next cmd is taken once the FSM is back in S_IDLE.
// A dump presents its values from S_DUMP, one per cycle while rsp is not stalled.
// rst is synchronous; it empties the set (cell valid bits and count).
// A stalled rsp holds the chain; a new cmd is taken while a result waits.
module sorted_unique_set #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst,
  suc_cmd_if.sink    cmd,
  suc_rsp_if.source  rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_APPLY, S_DUMP} state_t;

  state_t                             state;
  logic [suc_pkg::FUNC_W-1:0]         op_func;
  logic signed [suc_pkg::DATA_W-1:0]  op_value;
  logic [CNT_W-1:0]                   entry_count;
  logic [CNT_W-1:0]                   dump_left;

  logic                               rsp_valid;
  logic [suc_pkg::STATUS_W-1:0]       rsp_status;
  logic signed [suc_pkg::DATA_W-1:0]  rsp_entry_value;
  logic                               rsp_last;

  suc_pkg::cell_ctrl_t                ctrl;
  logic signed [suc_pkg::DATA_W-1:0]  cell_value [CAPACITY];
  logic [CAPACITY-1:0]                cell_valid;
  logic [CAPACITY-1:0]                cell_below;
  logic [CAPACITY-1:0]                cell_match;
  logic [CAPACITY-1:0]                count_mask;

  logic out_free;
  logic found;
  logic full;
  logic rsp_load;

  assign out_free  = !rsp_valid || rsp.ready;
  assign found     = |cell_match;
  assign full      = (entry_count == CNT_W'(CAPACITY));
  assign cmd.ready = (state == S_IDLE);

  assign rsp_load = out_free &&
                    ((state == S_APPLY &&
                      (op_func == suc_pkg::FUNC_INSERT || op_func == suc_pkg::FUNC_REMOVE ||
                       (op_func == suc_pkg::FUNC_DUMP && entry_count == '0))) ||
                     state == S_DUMP);

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.entry_value = rsp_entry_value;
  assign rsp.last        = rsp_last;

  always_comb begin
    ctrl.key = op_value;
    ctrl.op  = suc_pkg::CELL_HOLD;
    unique case (state)
      S_CMP: ctrl.op = suc_pkg::CELL_CMP;
      S_APPLY: begin
        if (out_free) begin
          if (op_func == suc_pkg::FUNC_INSERT && !found && !full) begin
            ctrl.op = suc_pkg::CELL_INS;
          end else if (op_func == suc_pkg::FUNC_REMOVE && found) begin
            ctrl.op = suc_pkg::CELL_DEL;
          end
        end
      end
      S_DUMP: begin
        if (out_free) begin
          ctrl.op = suc_pkg::CELL_ROT;
        end
      end
      default: ctrl.op = suc_pkg::CELL_HOLD;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [suc_pkg::DATA_W-1:0] lv;
    logic signed [suc_pkg::DATA_W-1:0] rv;
    logic                              lval;
    logic                              lbel;
    logic                              rval;

    if (i == 0) begin : g_first
      // The head sees a virtual neighbor below every key, so it can take the key.
      assign lv   = '0;
      assign lval = 1'b0;
      assign lbel = 1'b1;
    end else begin : g_mid_l
      assign lv   = cell_value[i-1];
      assign lval = cell_valid[i-1];
      assign lbel = cell_below[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rv   = '0;
      assign rval = 1'b0;
    end else begin : g_mid_r
      assign rv   = cell_value[i+1];
      assign rval = cell_valid[i+1];
    end

    suc_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .head_value  (cell_value[0]),
      .left_value  (lv),
      .left_valid  (lval),
      .left_below  (lbel),
      .right_value (rv),
      .right_valid (rval),
      .value       (cell_value[i]),
      .valid       (cell_valid[i]),
      .below       (cell_below[i]),
      .match       (cell_match[i])
    );

    assign count_mask[i] = (CNT_W'(i) < entry_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      dump_left   <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      // Hold a waiting result until it transfers.
      rsp_valid <= rsp_load || (rsp_valid && !rsp.ready);
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op_func  <= cmd.func;
            op_value <= cmd.value;
            // Drop the unused code without a result.
            if (cmd.func != suc_pkg::FUNC_INSERT && cmd.func != suc_pkg::FUNC_REMOVE &&
                cmd.func != suc_pkg::FUNC_DUMP) begin
              state <= S_IDLE;
            end else begin
              state <= S_CMP;
            end
          end
        end
        S_CMP: state <= S_APPLY;
        S_APPLY: begin
          if (out_free) begin
            rsp_entry_value <= '0;
            rsp_last        <= 1'b1;
            unique case (op_func)
              suc_pkg::FUNC_INSERT: begin
                state <= S_IDLE;
                if (found) begin
                  rsp_status <= suc_pkg::ST_DUP;
                end else if (full) begin
                  rsp_status <= suc_pkg::ST_FULL;
                end else begin
                  rsp_status  <= suc_pkg::ST_INSERTED;
                  entry_count <= entry_count + CNT_W'(1);
                end
              end
              suc_pkg::FUNC_REMOVE: begin
                state <= S_IDLE;
                if (found) begin
                  rsp_status  <= suc_pkg::ST_REMOVED;
                  entry_count <= entry_count - CNT_W'(1);
                end else begin
                  rsp_status <= suc_pkg::ST_NOTFOUND;
                end
              end
              suc_pkg::FUNC_DUMP: begin
                if (entry_count == '0) begin
                  rsp_status <= suc_pkg::ST_EMPTY;
                  state      <= S_IDLE;
                end else begin
                  dump_left <= entry_count;
                  state     <= S_DUMP;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_DUMP: begin
          // Emit the head each cycle that rsp is free, while the chain rotates one place.
          if (out_free) begin
            rsp_status      <= suc_pkg::ST_ENTRY;
            rsp_entry_value <= cell_value[0];
            rsp_last        <= (dump_left == CNT_W'(1));
            dump_left       <= dump_left - CNT_W'(1);
            if (dump_left == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    cell_valid == count_mask)
    else $error("cell valid bits disagree with entry count");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && out_free && op_func == suc_pkg::FUNC_INSERT && !found && !full)
    |=> entry_count == $past(entry_count) + CNT_W'(1))
    else $error("insert did not grow the set");

  a_dump_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP) |-> (dump_left != '0))
    else $error("dump running with nothing left");

endmodule
